// ----- sv/yuv_to_rgba_pixel_converter_top_defines.svh -----
// Assertion macros for the checker file of the pixel converter.
`ifndef YUV_TO_RGBA_PIXEL_CONVERTER_TOP_DEFINES_SVH
`define YUV_TO_RGBA_PIXEL_CONVERTER_TOP_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define YUVRGB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixel converter check failed");

// A stalled transfer must keep its payload unchanged into the next cycle.
`define YUVRGB_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("pixel converter payload changed while stalled");

`endif

// ----- sv/yuvrgb_pkg.sv -----
// Package with the types and constants of the pixel converter.
`default_nettype none

package yuvrgb_pkg;

  // Largest frame or window dimension; larger register values saturate to it.
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = $clog2(MaxDim + 1);
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RowW     = 12;
  localparam int unsigned DestW    = 24;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 56;

  // Derived widths of the index arithmetic.
  localparam int unsigned CfgProdW = 2 * DimW;
  localparam int unsigned BoundW   = 2 * DimW - 1;
  localparam int unsigned IdxProdW = RowW + DimW;
  localparam int unsigned IdxW     = (IdxProdW + 1 > DestW) ? IdxProdW + 1 : DestW;
  localparam int unsigned CiProdW  = RowW - 1 + DimW;
  localparam int unsigned CiW      = CiProdW + 1;
  localparam int unsigned CmpW     = (CiW + 1 > BoundW) ? CiW + 1 : BoundW;

  // Widths of the signed color sums.
  localparam int unsigned NvSumW = 20;
  localparam int unsigned QSumW  = 28;

  // Reset values of the dimension registers.
  localparam int unsigned RstFrameWidth  = 1280;
  localparam int unsigned RstFrameHeight = 720;
  localparam int unsigned RstWinWidth    = 1280;
  localparam int unsigned RstWinHeight   = 720;
  localparam int unsigned RstWinStride   = 1280;

  // Integer BT.601 coefficients.
  localparam int NvCoefY  = 298;
  localparam int NvCoefVr = 409;
  localparam int NvCoefUg = 100;
  localparam int NvCoefVg = 208;
  localparam int NvCoefUb = 516;
  localparam int NvRound  = 128;
  localparam int LumaOff  = 16;
  localparam int ChromaOff = 128;

  // Q16 coefficients of the floating BT.601 set, rounded to the nearest integer.
  localparam int QCoefVr = 91881;
  localparam int QCoefUg = 22544;
  localparam int QCoefVg = 46793;
  localparam int QCoefUb = 116130;

  // Output words.
  localparam logic [7:0]  AlphaByte  = 8'hFF;
  localparam logic [31:0] BandBlue   = 32'hFF0000FF;
  localparam logic [31:0] BandGreen  = 32'hFF00FF00;
  localparam logic [31:0] BandRed    = 32'hFFFF0000;

  // Source formats; the two unused codes behave as the test pattern.
  typedef enum logic [2:0] {
    FmtNv12   = 3'd0,
    FmtNv21   = 3'd1,
    FmtI420   = 3'd2,
    FmtRgb24  = 3'd3,
    FmtRgba32 = 3'd4,
    FmtTest   = 3'd5
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelFormat = 3'd0,
    CfgFrameWidth  = 3'd1,
    CfgFrameHeight = 3'd2,
    CfgWinWidth    = 3'd3,
    CfgWinHeight   = 3'd4,
    CfgWinStride   = 3'd5
  } cfg_idx_e;

  // Configuration as seen by the datapath, with derived limits.
  typedef struct packed {
    logic [2:0]        fmt;
    logic [DimW-1:0]   fw;
    logic [DimW-1:0]   ww;
    logic [DimW-1:0]   wh;
    logic [DimW-1:0]   st;
    logic [DimW-1:0]   lim_w;
    logic [DimW-1:0]   lim_h;
    logic [BoundW-1:0] bound;
    logic [DimW-1:0]   wh_third;
    logic [DimW-1:0]   wh_two_third;
  } cfg_t;

  // One input pixel, last field in the lowest bits.
  typedef struct packed {
    logic [31:0]     word;
    logic [7:0]      s2;
    logic [7:0]      s1;
    logic [7:0]      s0;
    logic [RowW-1:0] col;
    logic [RowW-1:0] row;
  } pix_in_t;

  // Intermediate values between the product stage and the result stage.
  typedef struct packed {
    logic [2:0]               fmt;
    logic                     area_ok;
    logic                     test_ok;
    logic [31:0]              band_word;
    logic [IdxProdW-1:0]      idx_prod;
    logic [RowW-1:0]          col;
    logic [CiProdW-1:0]       ci_prod;
    logic signed [NvSumW-1:0] nv_r;
    logic signed [NvSumW-1:0] nv_g;
    logic signed [NvSumW-1:0] nv_b;
    logic signed [QSumW-1:0]  q_r;
    logic signed [QSumW-1:0]  q_g;
    logic signed [QSumW-1:0]  q_b;
    logic [31:0]              raw_word;
  } prod_t;

  // One result item.
  typedef struct packed {
    logic             we;
    logic [DestW-1:0] dest;
    logic [31:0]      word;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/yuv_to_rgba_pixel_converter_top.sv -----
// Top level of the YUV/RGB to packed RGBA pixel converter.
`default_nettype none

// Converts one pixel per clock, while the output side is ready, into a write
// flag, a destination index (row * stride + column, modulo 2^24) and a
// 0xAARRGGBB word. Each transfer passes three register stages (input,
// product, result) in that order; a new pixel may be accepted in every cycle
// while the output side is ready. The multipliers of the product stage (row
// times stride, half row times frame width) set the clock rate. The
// configuration port is always ready; limits derived from a write (window
// minima, chroma plane bound, band rows) settle in the cycle after it.
// A stalled output holds its transfer while the earlier stages keep filling.
module yuv_to_rgba_pixel_converter_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input pixel stream.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata fields from bit 0: pixel_row[11:0], pixel_col[11:0], luma_or_red[7:0],
  // chroma_first[7:0], chroma_second[7:0], source_word[31:0].
  input  wire logic [yuvrgb_pkg::InDataW-1:0]      s_axis_tdata_i,
  // Result stream.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tuser fields from bit 0: write_enable.
  output logic                                     m_axis_tuser_o,
  // tdata fields from bit 0: dest_index[23:0], pixel_word[31:0].
  output logic [yuvrgb_pkg::OutDataW-1:0]          m_axis_tdata_o,
  // Configuration write channel.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [yuvrgb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [yuvrgb_pkg::CfgDataW-1:0]    cfg_data_i
);

  yuvrgb_pkg::cfg_t    cfg;
  yuvrgb_pkg::pix_in_t pix_q;
  yuvrgb_pkg::prod_t   prod;
  yuvrgb_pkg::res_t    res;
  logic                in_v_q, prod_v_q, out_v_q;
  logic                en_in, en_prod, en_out;
  logic                out_we_q;
  logic [yuvrgb_pkg::OutDataW-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;

  yuvrgb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A stage advances when it is empty or the stage after it advances.
  assign en_out          = !out_v_q || m_axis_tready_i;
  assign en_prod         = !prod_v_q || en_out;
  assign en_in           = !in_v_q || en_prod;
  assign s_axis_tready_o = en_in;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (en_in) begin
        in_v_q <= s_axis_tvalid_i;
      end
      if (en_prod) begin
        prod_v_q <= in_v_q;
      end
      if (en_out) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en_in) begin
      pix_q <= yuvrgb_pkg::pix_in_t'(s_axis_tdata_i);
    end
  end

  yuvrgb_prod u_prod (
    .clk_i  (clk_i),
    .en_i   (en_prod),
    .pix_i  (pix_q),
    .cfg_i  (cfg),
    .prod_o (prod)
  );

  yuvrgb_finish u_finish (
    .prod_i (prod),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_we_q   <= res.we;
      out_data_q <= {res.word, res.dest};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_we_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ----- sv/yuvrgb_cfg.sv -----
// Configuration registers with dimension saturation and derived limits.
`default_nettype none

module yuvrgb_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [yuvrgb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [yuvrgb_pkg::CfgDataW-1:0] cfg_data_i,
  output yuvrgb_pkg::cfg_t                      cfg_o
);

  localparam int unsigned DimW     = yuvrgb_pkg::DimW;
  localparam int unsigned Div3W    = DimW + 16;
  localparam int unsigned Div3Mul  = 21846;

  // Saturate a written dimension to the largest supported value.
  function automatic logic [DimW-1:0] sat_dim(input logic [yuvrgb_pkg::CfgDataW-1:0] v);
    logic [DimW-1:0] r;
    if (32'(v) > yuvrgb_pkg::MaxDim) begin
      r = DimW'(yuvrgb_pkg::MaxDim);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  // Floor of v / 3 by reciprocal multiplication; exact for all v below 2^15.
  function automatic logic [DimW-1:0] div3(input logic [DimW:0] v);
    logic [Div3W-1:0] p;
    p = Div3W'(v) * Div3W'(Div3Mul);
    return DimW'(p >> 16);
  endfunction

  logic [2:0]      fmt_q;
  logic [DimW-1:0] fw_q, fh_q, ww_q, wh_q, st_q;
  logic [DimW-1:0] lim_w_q, lim_h_q, third_q, two_third_q;
  logic [yuvrgb_pkg::BoundW-1:0]   bound_q;
  logic [yuvrgb_pkg::CfgProdW-1:0] area_prod;

  assign area_prod = yuvrgb_pkg::CfgProdW'(fw_q) * yuvrgb_pkg::CfgProdW'(fh_q);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= yuvrgb_pkg::FmtNv12;
      fw_q  <= sat_dim(yuvrgb_pkg::CfgDataW'(yuvrgb_pkg::RstFrameWidth));
      fh_q  <= sat_dim(yuvrgb_pkg::CfgDataW'(yuvrgb_pkg::RstFrameHeight));
      ww_q  <= sat_dim(yuvrgb_pkg::CfgDataW'(yuvrgb_pkg::RstWinWidth));
      wh_q  <= sat_dim(yuvrgb_pkg::CfgDataW'(yuvrgb_pkg::RstWinHeight));
      st_q  <= sat_dim(yuvrgb_pkg::CfgDataW'(yuvrgb_pkg::RstWinStride));
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        yuvrgb_pkg::CfgPixelFormat: fmt_q <= cfg_data_i[2:0];
        yuvrgb_pkg::CfgFrameWidth:  fw_q  <= sat_dim(cfg_data_i);
        yuvrgb_pkg::CfgFrameHeight: fh_q  <= sat_dim(cfg_data_i);
        yuvrgb_pkg::CfgWinWidth:    ww_q  <= sat_dim(cfg_data_i);
        yuvrgb_pkg::CfgWinHeight:   wh_q  <= sat_dim(cfg_data_i);
        yuvrgb_pkg::CfgWinStride:   st_q  <= sat_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Derived limits follow the registers in the next cycle.
  always_ff @(posedge clk_i) begin
    lim_w_q     <= (fw_q < ww_q) ? fw_q : ww_q;
    lim_h_q     <= (fh_q < wh_q) ? fh_q : wh_q;
    bound_q     <= yuvrgb_pkg::BoundW'(area_prod >> 1);
    third_q     <= div3({1'b0, wh_q});
    two_third_q <= div3({wh_q, 1'b0});
  end

  always_comb begin
    cfg_o.fmt          = fmt_q;
    cfg_o.fw           = fw_q;
    cfg_o.ww           = ww_q;
    cfg_o.wh           = wh_q;
    cfg_o.st           = st_q;
    cfg_o.lim_w        = lim_w_q;
    cfg_o.lim_h        = lim_h_q;
    cfg_o.bound        = bound_q;
    cfg_o.wh_third     = third_q;
    cfg_o.wh_two_third = two_third_q;
  end

endmodule

`default_nettype wire

// ----- sv/yuvrgb_prod.sv -----
// Product stage: index products, color sums and area checks, registered.
`default_nettype none

module yuvrgb_prod (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire yuvrgb_pkg::pix_in_t pix_i,
  input  wire yuvrgb_pkg::cfg_t    cfg_i,
  output yuvrgb_pkg::prod_t        prod_o
);

  localparam int unsigned NvW = yuvrgb_pkg::NvSumW;
  localparam int unsigned QW  = yuvrgb_pkg::QSumW;

  localparam logic signed [NvW-1:0] KNvY   = NvW'(yuvrgb_pkg::NvCoefY);
  localparam logic signed [NvW-1:0] KNvVr  = NvW'(yuvrgb_pkg::NvCoefVr);
  localparam logic signed [NvW-1:0] KNvUg  = NvW'(yuvrgb_pkg::NvCoefUg);
  localparam logic signed [NvW-1:0] KNvVg  = NvW'(yuvrgb_pkg::NvCoefVg);
  localparam logic signed [NvW-1:0] KNvUb  = NvW'(yuvrgb_pkg::NvCoefUb);
  localparam logic signed [NvW-1:0] KNvRnd = NvW'(yuvrgb_pkg::NvRound);
  localparam logic signed [QW-1:0]  KQVr   = QW'(yuvrgb_pkg::QCoefVr);
  localparam logic signed [QW-1:0]  KQUg   = QW'(yuvrgb_pkg::QCoefUg);
  localparam logic signed [QW-1:0]  KQVg   = QW'(yuvrgb_pkg::QCoefVg);
  localparam logic signed [QW-1:0]  KQUb   = QW'(yuvrgb_pkg::QCoefUb);

  logic [7:0]              y, u, v;
  logic signed [9:0]       c_s, d_s, e_s;
  logic signed [NvW-1:0]   c_n, d_n, e_n;
  logic signed [QW-1:0]    yy_q, d_q, e_q;
  yuvrgb_pkg::prod_t       prod_d;
  yuvrgb_pkg::prod_t       prod_q;

  // Chroma byte order depends on the format.
  always_comb begin
    y = pix_i.s0;
    case (cfg_i.fmt)
      yuvrgb_pkg::FmtNv21: begin
        u = pix_i.s2;
        v = pix_i.s1;
      end
      default: begin
        u = pix_i.s1;
        v = pix_i.s2;
      end
    endcase
  end

  // Offset samples and the color sums of both conversions.
  always_comb begin
    c_s  = $signed({2'b00, y}) - 10'(yuvrgb_pkg::LumaOff);
    d_s  = $signed({2'b00, u}) - 10'(yuvrgb_pkg::ChromaOff);
    e_s  = $signed({2'b00, v}) - 10'(yuvrgb_pkg::ChromaOff);
    c_n  = NvW'(c_s);
    d_n  = NvW'(d_s);
    e_n  = NvW'(e_s);
    d_q  = QW'(d_s);
    e_q  = QW'(e_s);
    yy_q = QW'($signed({1'b0, y, 16'h0000}));

    prod_d.nv_r = KNvY * c_n + KNvVr * e_n + KNvRnd;
    prod_d.nv_g = KNvY * c_n - KNvUg * d_n - KNvVg * e_n + KNvRnd;
    prod_d.nv_b = KNvY * c_n + KNvUb * d_n + KNvRnd;
    prod_d.q_r  = yy_q + KQVr * e_q;
    prod_d.q_g  = yy_q - KQUg * d_q - KQVg * e_q;
    prod_d.q_b  = yy_q + KQUb * d_q;

    // Index products, area checks and the pass-through words.
    prod_d.fmt      = cfg_i.fmt;
    prod_d.area_ok  = (pix_i.row < cfg_i.lim_h) && (pix_i.col < cfg_i.lim_w);
    prod_d.test_ok  = (pix_i.row < cfg_i.wh) && (pix_i.col < cfg_i.ww);
    if (pix_i.row < cfg_i.wh_third) begin
      prod_d.band_word = yuvrgb_pkg::BandBlue;
    end else if (pix_i.row < cfg_i.wh_two_third) begin
      prod_d.band_word = yuvrgb_pkg::BandGreen;
    end else begin
      prod_d.band_word = yuvrgb_pkg::BandRed;
    end
    prod_d.idx_prod = yuvrgb_pkg::IdxProdW'(pix_i.row) * yuvrgb_pkg::IdxProdW'(cfg_i.st);
    prod_d.col      = pix_i.col;
    prod_d.ci_prod  = yuvrgb_pkg::CiProdW'(pix_i.row[yuvrgb_pkg::RowW-1:1])
                      * yuvrgb_pkg::CiProdW'(cfg_i.fw);
    if (cfg_i.fmt == yuvrgb_pkg::FmtRgb24) begin
      prod_d.raw_word = {yuvrgb_pkg::AlphaByte, pix_i.s0, pix_i.s1, pix_i.s2};
    end else begin
      prod_d.raw_word = pix_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- sv/yuvrgb_finish.sv -----
// Result stage logic: clamping, chroma bound, format select and index sum.
`default_nettype none

module yuvrgb_finish (
  input  wire yuvrgb_pkg::prod_t prod_i,
  input  wire yuvrgb_pkg::cfg_t  cfg_i,
  output yuvrgb_pkg::res_t       res_o
);

  localparam int unsigned NvW = yuvrgb_pkg::NvSumW;
  localparam int unsigned QW  = yuvrgb_pkg::QSumW;

  // Floor by 256, then clamp to a byte; negative sums give zero.
  function automatic logic [7:0] clamp_nv(input logic signed [NvW-1:0] s);
    logic [7:0] r;
    if (s[NvW-1]) begin
      r = 8'h00;
    end else if (|s[NvW-1:16]) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

  // Truncate a Q16 sum, then clamp to a byte; negative sums give zero.
  function automatic logic [7:0] clamp_q(input logic signed [QW-1:0] s);
    logic [7:0] r;
    if (s[QW-1]) begin
      r = 8'h00;
    end else if (|s[QW-1:24]) begin
      r = 8'hFF;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

  logic [yuvrgb_pkg::CiW-1:0]  ci;
  logic                        chroma_ok;
  logic [yuvrgb_pkg::IdxW-1:0] idx_sum;
  logic                        we;
  logic [31:0]                 px;

  // NV12 chroma plane bound and the destination index.
  always_comb begin
    ci = yuvrgb_pkg::CiW'(prod_i.ci_prod)
         + yuvrgb_pkg::CiW'({prod_i.col[yuvrgb_pkg::RowW-1:1], 1'b0});
    chroma_ok = (yuvrgb_pkg::CmpW'(ci) + yuvrgb_pkg::CmpW'(1))
                < yuvrgb_pkg::CmpW'(cfg_i.bound);
    idx_sum = yuvrgb_pkg::IdxW'(prod_i.idx_prod) + yuvrgb_pkg::IdxW'(prod_i.col);
  end

  // Format select and write decision.
  always_comb begin
    we = prod_i.area_ok;
    px = prod_i.raw_word;
    case (prod_i.fmt) inside
      yuvrgb_pkg::FmtNv12: begin
        we = prod_i.area_ok && chroma_ok;
        px = {yuvrgb_pkg::AlphaByte, clamp_nv(prod_i.nv_r), clamp_nv(prod_i.nv_g),
              clamp_nv(prod_i.nv_b)};
      end
      yuvrgb_pkg::FmtNv21, yuvrgb_pkg::FmtI420: begin
        px = {yuvrgb_pkg::AlphaByte, clamp_q(prod_i.q_r), clamp_q(prod_i.q_g),
              clamp_q(prod_i.q_b)};
      end
      yuvrgb_pkg::FmtRgb24, yuvrgb_pkg::FmtRgba32: begin
        px = prod_i.raw_word;
      end
      default: begin
        we = prod_i.test_ok;
        px = prod_i.band_word;
      end
    endcase
  end

  // Skipped pixels carry zero fields.
  always_comb begin
    res_o.we   = we;
    res_o.dest = we ? idx_sum[yuvrgb_pkg::DestW-1:0] : '0;
    res_o.word = we ? px : '0;
  end

endmodule

`default_nettype wire

// ----- sv/yuvrgb_checker.sv -----
// Port-level checker of the pixel converter and its bind statement.
`default_nettype none

`include "yuv_to_rgba_pixel_converter_top_defines.svh"

module yuvrgb_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic                            m_axis_tuser_o,
  input wire logic [yuvrgb_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // A skipped pixel carries a zero index and a zero word.
  `YUVRGB_ASSERT_IMPL(a_skip_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)

  // With the result register free to move, the input side must take transfers.
  `YUVRGB_ASSERT_IMPL(a_ready_free, !m_axis_tvalid_o || m_axis_tready_i, s_axis_tready_o)

  // A stalled result keeps its fields.
  `YUVRGB_ASSERT_HOLD(a_out_hold, m_axis_tvalid_o, m_axis_tready_i, {m_axis_tuser_o, m_axis_tdata_o})

endmodule

bind yuv_to_rgba_pixel_converter_top yuvrgb_checker u_yuvrgb_checker (.*);

`default_nettype wire

// ----- test/yuv_to_rgba_pixel_converter_top_test.sv -----
// Self-checking testbench of the pixel converter: directed vectors, then randomized phases.
`timescale 1ns / 1ps

module yuv_to_rgba_pixel_converter_top_test;

  // Format codes past the test pattern behave as the test pattern.
  localparam logic [2:0] FmtSpareA = 3'd6;
  localparam logic [2:0] FmtSpareB = 3'd7;
  // Register indexes with no register behind them; writes there are ignored.
  localparam logic [2:0] CfgSpareA = 3'd6;
  localparam logic [2:0] CfgSpareB = 3'd7;

  // Geometry sets of the directed part.
  localparam logic [1:0] DimsReset = 2'd0;
  localparam logic [1:0] DimsOdd   = 2'd1;
  localparam logic [1:0] DimsFull  = 2'd2;
  localparam logic [1:0] DimsZero  = 2'd3;

  localparam int QuietLimit    = 2000;
  localparam int RandPhases    = 12;
  localparam int ItemsPerPhase = 125;
  localparam int DirCount      = 25;

  typedef struct packed {
    logic [12:0] fw;
    logic [12:0] fh;
    logic [12:0] ww;
    logic [12:0] wh;
    logic [12:0] st;
  } geom_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [1:0]  dims;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [31:0] word;
    logic        known;
    logic        exp_we;
    logic [23:0] exp_dest;
    logic [31:0] exp_word;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [yuvrgb_pkg::InDataW-1:0]  s_axis_tdata_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  logic                            m_axis_tuser_o;
  logic [yuvrgb_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [yuvrgb_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [yuvrgb_pkg::CfgDataW-1:0] cfg_data_i;

  yuv_to_rgba_pixel_converter_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow copy of the converter registers, starting from their reset values.
  logic [2:0] cfg_fmt  = yuvrgb_pkg::FmtNv12;
  geom_t      cfg_geom = '{13'(yuvrgb_pkg::RstFrameWidth), 13'(yuvrgb_pkg::RstFrameHeight),
                           13'(yuvrgb_pkg::RstWinWidth), 13'(yuvrgb_pkg::RstWinHeight),
                           13'(yuvrgb_pkg::RstWinStride)};

  yuvrgb_pkg::res_t pending_writes[$];
  logic             typed_on;
  yuvrgb_pkg::res_t typed_res;
  logic             src_idle_on;
  logic             snk_idle_on;
  int               snk_stall;
  int               quiet_cycles;
  logic             timed_out;
  int               error_count;
  int               n_out;
  int               n_written;
  int               n_settings;

  // Directed vectors: reset geometry first, then odd, oversized and zero geometry.
  dir_row_t dir_rows [DirCount] = '{
    '{yuvrgb_pkg::FmtNv12, DimsReset, 0, 0, 16, 128, 128, 0, 1, 1, 0, 32'hFF000000},
    '{yuvrgb_pkg::FmtNv12, DimsReset, 719, 1279, 235, 128, 128, 0, 1, 1, 24'h0E0FFF,
      32'hFFFFFFFF},
    '{yuvrgb_pkg::FmtNv12, DimsReset, 720, 0, 99, 99, 99, 0, 1, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv12, DimsReset, 0, 1280, 99, 99, 99, 0, 1, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv12, DimsReset, 10, 20, 255, 0, 255, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv21, DimsReset, 12, 13, 0, 0, 0, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv21, DimsReset, 14, 15, 255, 255, 255, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv21, DimsReset, 5, 7, 128, 128, 128, 0, 1, 1, 24'h001907, 32'hFF808080},
    '{yuvrgb_pkg::FmtI420, DimsReset, 100, 200, 255, 0, 255, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtI420, DimsReset, 101, 201, 0, 255, 0, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtI420, DimsReset, 4095, 4095, 7, 7, 7, 0, 1, 0, 0, 0},
    '{yuvrgb_pkg::FmtRgb24, DimsReset, 2, 3, 'h12, 'h34, 'h56, 0, 1, 1, 24'h000A03,
      32'hFF123456},
    '{yuvrgb_pkg::FmtRgba32, DimsReset, 0, 0, 1, 2, 3, 32'hDEADBEEF, 1, 1, 0, 32'hDEADBEEF},
    '{yuvrgb_pkg::FmtRgba32, DimsReset, 719, 1279, 1, 2, 3, 32'h0, 1, 1, 24'h0E0FFF, 32'h0},
    '{yuvrgb_pkg::FmtTest, DimsReset, 0, 0, 0, 0, 0, 0, 1, 1, 0, yuvrgb_pkg::BandBlue},
    '{yuvrgb_pkg::FmtTest, DimsReset, 240, 0, 0, 0, 0, 0, 1, 1, 24'h04B000,
      yuvrgb_pkg::BandGreen},
    '{yuvrgb_pkg::FmtTest, DimsReset, 480, 0, 0, 0, 0, 0, 1, 1, 24'h096000,
      yuvrgb_pkg::BandRed},
    '{yuvrgb_pkg::FmtTest, DimsReset, 239, 1279, 0, 0, 0, 0, 1, 1, 24'h04AFFF,
      yuvrgb_pkg::BandBlue},
    '{FmtSpareA, DimsReset, 479, 5, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FmtSpareB, DimsReset, 720, 5, 0, 0, 0, 0, 1, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv12, DimsOdd, 4, 2, 50, 60, 70, 0, 1, 0, 0, 0},
    '{yuvrgb_pkg::FmtNv12, DimsOdd, 4, 0, 120, 60, 200, 0, 0, 0, 0, 0},
    '{yuvrgb_pkg::FmtTest, DimsFull, 4095, 4095, 0, 0, 0, 0, 1, 1, 24'hFFFFFF,
      yuvrgb_pkg::BandRed},
    '{yuvrgb_pkg::FmtRgb24, DimsFull, 4095, 4095, 255, 255, 255, 0, 1, 1, 24'hFFFFFF,
      32'hFFFFFFFF},
    '{yuvrgb_pkg::FmtI420, DimsZero, 0, 0, 9, 9, 9, 0, 1, 0, 0, 0}
  };

  always #5 clk_i = ~clk_i;

  // Register values above the largest dimension saturate to it.
  function automatic int unsigned clip_dim(logic [12:0] v);
    return (v > yuvrgb_pkg::MaxDim) ? yuvrgb_pkg::MaxDim : int'(v);
  endfunction

  function automatic logic [7:0] clamp_byte(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Q16 BT.601 conversion; signed division truncates toward zero.
  function automatic logic [31:0] q16_to_word(longint y, longint u, longint v);
    longint yy, dd, ee;
    yy = y * 65536;
    dd = u - yuvrgb_pkg::ChromaOff;
    ee = v - yuvrgb_pkg::ChromaOff;
    return {yuvrgb_pkg::AlphaByte,
            clamp_byte((yy + yuvrgb_pkg::QCoefVr * ee) / 65536),
            clamp_byte((yy - yuvrgb_pkg::QCoefUg * dd - yuvrgb_pkg::QCoefVg * ee) / 65536),
            clamp_byte((yy + yuvrgb_pkg::QCoefUb * dd) / 65536)};
  endfunction

  // Expected write for one pixel under the current register values.
  function automatic yuvrgb_pkg::res_t convert_pixel(yuvrgb_pkg::pix_in_t p);
    yuvrgb_pkg::res_t r;
    int unsigned fw, fh, ww, wh, st, lim_w, lim_h;
    longint unsigned rr, cc, ci, bound;
    longint y0, u0, v0, c, d, e;
    logic on;
    logic [31:0] px;
    fw = clip_dim(cfg_geom.fw);
    fh = clip_dim(cfg_geom.fh);
    ww = clip_dim(cfg_geom.ww);
    wh = clip_dim(cfg_geom.wh);
    st = clip_dim(cfg_geom.st);
    lim_w = (fw < ww) ? fw : ww;
    lim_h = (fh < wh) ? fh : wh;
    rr = p.row;
    cc = p.col;
    y0 = p.s0;
    u0 = p.s1;
    v0 = p.s2;
    on = 1'b0;
    px = '0;
    if (cfg_fmt >= yuvrgb_pkg::FmtTest) begin
      // Test pattern: three horizontal bands over the window only.
      if (rr < wh && cc < ww) begin
        on = 1'b1;
        if (rr < wh / 3) px = yuvrgb_pkg::BandBlue;
        else if (rr < (2 * wh) / 3) px = yuvrgb_pkg::BandGreen;
        else px = yuvrgb_pkg::BandRed;
      end
    end else if (rr < lim_h && cc < lim_w) begin
      on = 1'b1;
      case (cfg_fmt)
        yuvrgb_pkg::FmtNv12: begin
          // The interleaved chroma sample must lie inside the plane.
          ci = (rr / 2) * fw + (cc & ~64'd1);
          bound = (longint'(fw) * fh) / 2;
          if (ci + 1 >= bound) begin
            on = 1'b0;
          end else begin
            c = y0 - yuvrgb_pkg::LumaOff;
            d = u0 - yuvrgb_pkg::ChromaOff;
            e = v0 - yuvrgb_pkg::ChromaOff;
            px = {yuvrgb_pkg::AlphaByte,
                  clamp_byte((yuvrgb_pkg::NvCoefY * c + yuvrgb_pkg::NvCoefVr * e
                              + yuvrgb_pkg::NvRound) >>> 8),
                  clamp_byte((yuvrgb_pkg::NvCoefY * c - yuvrgb_pkg::NvCoefUg * d
                              - yuvrgb_pkg::NvCoefVg * e + yuvrgb_pkg::NvRound) >>> 8),
                  clamp_byte((yuvrgb_pkg::NvCoefY * c + yuvrgb_pkg::NvCoefUb * d
                              + yuvrgb_pkg::NvRound) >>> 8)};
          end
        end
        yuvrgb_pkg::FmtNv21:  px = q16_to_word(y0, v0, u0);
        yuvrgb_pkg::FmtI420:  px = q16_to_word(y0, u0, v0);
        yuvrgb_pkg::FmtRgb24: px = {yuvrgb_pkg::AlphaByte, p.s0, p.s1, p.s2};
        default:              px = p.word;
      endcase
    end
    r.we   = on;
    r.dest = on ? yuvrgb_pkg::DestW'(rr * st + cc) : '0;
    r.word = on ? px : '0;
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // Both streams and the configuration channel, sampled at the rising edge.
  always @(posedge clk_i) begin
    yuvrgb_pkg::res_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid_i && s_axis_tready_o)
        pending_writes.push_back(typed_on ? typed_res : convert_pixel(s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.we   = m_axis_tuser_o;
        got.dest = m_axis_tdata_o[yuvrgb_pkg::DestW-1:0];
        got.word = m_axis_tdata_o[yuvrgb_pkg::DestW +: 32];
        if (got.we === 1'b1) n_written++;
        if (pending_writes.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", n_out));
        end else begin
          want = pending_writes.pop_front();
          if (got.we !== want.we)
            flag_error($sformatf("result %0d: write flag %b, expected %b",
                                 n_out, got.we, want.we));
          if (got.dest !== want.dest)
            flag_error($sformatf("result %0d: index %h, expected %h",
                                 n_out, got.dest, want.dest));
          if (got.word !== want.word)
            flag_error($sformatf("result %0d: word %h, expected %h",
                                 n_out, got.word, want.word));
        end
        n_out++;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (snk_stall > 0) begin
      snk_stall--;
      m_axis_tready_i = 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
      snk_stall = $urandom_range(0, 14);
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  // One pixel transfer, with an optional idle burst ahead of it.
  task automatic send_pixel(yuvrgb_pkg::pix_in_t p, logic typed, yuvrgb_pkg::res_t want);
    @(negedge clk_i);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = p;
    typed_on        = typed;
    typed_res       = want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // One register write; the shadow copy follows at the transfer.
  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      yuvrgb_pkg::CfgPixelFormat: cfg_fmt = data[2:0];
      yuvrgb_pkg::CfgFrameWidth:  cfg_geom.fw = data;
      yuvrgb_pkg::CfgFrameHeight: cfg_geom.fh = data;
      yuvrgb_pkg::CfgWinWidth:    cfg_geom.ww = data;
      yuvrgb_pkg::CfgWinHeight:   cfg_geom.wh = data;
      yuvrgb_pkg::CfgWinStride:   cfg_geom.st = data;
      default: ;
    endcase
  endtask

  // Registers change only once the converter has delivered everything.
  task automatic configure(logic [12:0] fmt_word, geom_t g, logic with_spare);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    write_reg(yuvrgb_pkg::CfgPixelFormat, fmt_word);
    write_reg(yuvrgb_pkg::CfgFrameWidth, g.fw);
    write_reg(yuvrgb_pkg::CfgFrameHeight, g.fh);
    write_reg(yuvrgb_pkg::CfgWinWidth, g.ww);
    write_reg(yuvrgb_pkg::CfgWinHeight, g.wh);
    write_reg(yuvrgb_pkg::CfgWinStride, g.st);
    if (with_spare) begin
      write_reg(CfgSpareA, 13'($urandom));
      write_reg(CfgSpareB, 13'($urandom));
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    // Derived limits settle in the cycle after the last write.
    repeat (2) @(negedge clk_i);
    n_settings++;
  endtask

  // Dimensions: mostly small or moderate, sometimes maximal, oversized or zero.
  function automatic logic [12:0] pick_dim();
    int unsigned k;
    k = $urandom_range(0, 39);
    if (k == 0) return 13'd0;
    if (k <= 6) return 13'(yuvrgb_pkg::MaxDim);
    if (k <= 10) return 13'($urandom_range(yuvrgb_pkg::MaxDim + 1, 8191));
    if (k <= 20) return 13'($urandom_range(1, 16));
    if (k <= 32) return 13'($urandom_range(17, 1024));
    return 13'($urandom_range(1, yuvrgb_pkg::MaxDim));
  endfunction

  // Coordinates cluster inside the area, on its last line and just past it.
  function automatic logic [11:0] pick_coord(int unsigned lim);
    case ($urandom_range(0, 7))
      0:       return 12'($urandom);
      1:       return 12'(lim);
      2:       return 12'((lim == 0) ? 0 : lim - 1);
      default: return 12'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0]          cur_fmt;
    logic [1:0]          cur_dims;
    logic [12:0]         fmt_word;
    geom_t               geo;
    yuvrgb_pkg::pix_in_t px;
    yuvrgb_pkg::res_t    want;
    int unsigned         lim_r, lim_c;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    typed_on        = 1'b0;
    typed_res       = '0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    snk_stall       = 0;
    quiet_cycles    = 0;
    timed_out       = 1'b0;
    error_count     = 0;
    n_out           = 0;
    n_written       = 0;
    n_settings      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        // Directed part; the first rows run on the reset register values.
        cur_fmt  = yuvrgb_pkg::FmtNv12;
        cur_dims = DimsReset;
        foreach (dir_rows[i]) begin
          if (dir_rows[i].fmt != cur_fmt || dir_rows[i].dims != cur_dims) begin
            cur_fmt  = dir_rows[i].fmt;
            cur_dims = dir_rows[i].dims;
            case (cur_dims)
              DimsReset: geo = '{13'(yuvrgb_pkg::RstFrameWidth),
                                 13'(yuvrgb_pkg::RstFrameHeight),
                                 13'(yuvrgb_pkg::RstWinWidth),
                                 13'(yuvrgb_pkg::RstWinHeight),
                                 13'(yuvrgb_pkg::RstWinStride)};
              DimsOdd:   geo = '{13'd5, 13'd5, 13'd6, 13'd6, 13'd7};
              DimsFull:  geo = '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF};
              default:   geo = '0;
            endcase
            configure({10'd0, cur_fmt}, geo, 1'b0);
          end
          px   = '{word: dir_rows[i].word, s2: dir_rows[i].s2, s1: dir_rows[i].s1,
                   s0: dir_rows[i].s0, col: dir_rows[i].col, row: dir_rows[i].row};
          want = '{we: dir_rows[i].exp_we, dest: dir_rows[i].exp_dest,
                   word: dir_rows[i].exp_word};
          send_pixel(px, dir_rows[i].known, want);
        end

        // Random phases; each one drains, reprograms every register and streams.
        for (int ph = 0; ph < RandPhases; ph++) begin
          src_idle_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
          snk_idle_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
          fmt_word = 13'((ph < 8) ? ph : $urandom_range(0, 7));
          if ($urandom_range(0, 3) == 0) fmt_word[12:3] = 10'($urandom);
          geo = '{pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_dim()};
          configure(fmt_word, geo, ph == 2);
          lim_r = clip_dim(cfg_geom.wh);
          lim_c = clip_dim(cfg_geom.ww);
          if (cfg_fmt < yuvrgb_pkg::FmtTest) begin
            if (clip_dim(cfg_geom.fh) < lim_r) lim_r = clip_dim(cfg_geom.fh);
            if (clip_dim(cfg_geom.fw) < lim_c) lim_c = clip_dim(cfg_geom.fw);
          end
          if (lim_r > 4095) lim_r = 4095;
          if (lim_c > 4095) lim_c = 4095;
          for (int k = 0; k < ItemsPerPhase; k++) begin
            px = '{word: $urandom, s2: pick_byte(), s1: pick_byte(), s0: pick_byte(),
                   col: pick_coord(lim_c), row: pick_coord(lim_r)};
            send_pixel(px, 1'b0, '0);
          end
        end

        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
        while (pending_writes.size() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      begin
        wait (quiet_cycles >= QuietLimit);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out)
      flag_error($sformatf("no transfer for %0d cycles", QuietLimit));
    else if (pending_writes.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_writes.size()));
    $display("Checked %0d results (%0d written, %0d skipped) over %0d register settings,",
             n_out, n_written, n_out - n_written, n_settings);
    $display("covering all six formats, both unused format codes and unused register slots.");
    if (error_count == 0 && !timed_out) begin
      $display("yuv_to_rgba_pixel_converter_top_test: PASS");
    end else begin
      $display("yuv_to_rgba_pixel_converter_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/yuvrgb_pkg.sv
sv/yuvrgb_cfg.sv
sv/yuvrgb_prod.sv
sv/yuvrgb_finish.sv
sv/yuv_to_rgba_pixel_converter_top.sv
sv/yuvrgb_checker.sv
test/yuv_to_rgba_pixel_converter_top_test.sv
